// ----- rtl/jse_pkg.sv -----
// ----------------------------------------------------------------------------
// JSON string escaper package
// Shared request descriptor, character codes and the hex digit table.
// ----------------------------------------------------------------------------
package jse_pkg;

    typedef enum logic [1:0] {
        KIND_RAW,
        KIND_PAIR,
        KIND_UESC,
        KIND_EMPTY
    } jse_kind_t;

    typedef struct packed {
        jse_kind_t   kind;
        logic [15:0] ch;
        logic        first;
        logic        last;
    } jse_desc_t;

    localparam logic [15:0] CH_NUL    = 16'h0000;
    localparam logic [15:0] CH_BS     = 16'h0008;
    localparam logic [15:0] CH_TAB    = 16'h0009;
    localparam logic [15:0] CH_LF     = 16'h000A;
    localparam logic [15:0] CH_FF     = 16'h000C;
    localparam logic [15:0] CH_CR     = 16'h000D;
    localparam logic [15:0] CH_SPACE  = 16'h0020;
    localparam logic [15:0] CH_QUOTE  = 16'h0022;
    localparam logic [15:0] CH_SLASH  = 16'h002F;
    localparam logic [15:0] CH_ZERO   = 16'h0030;
    localparam logic [15:0] CH_BSLASH = 16'h005C;
    localparam logic [15:0] CH_LOW_B  = 16'h0062;
    localparam logic [15:0] CH_LOW_F  = 16'h0066;
    localparam logic [15:0] CH_LOW_N  = 16'h006E;
    localparam logic [15:0] CH_LOW_R  = 16'h0072;
    localparam logic [15:0] CH_LOW_T  = 16'h0074;
    localparam logic [15:0] CH_LOW_U  = 16'h0075;

    localparam logic [7:0] HEX_DIGIT [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };

    function automatic logic [15:0] hex_char(input logic [3:0] nib);
        return {8'h00, HEX_DIGIT[nib]};
    endfunction

endpackage

// ----- rtl/jse_if.sv -----
// ----------------------------------------------------------------------------
// JSON string escaper channels
// Valid/ready channels for code units, escaped characters and configuration.
// ----------------------------------------------------------------------------
interface jse_unit_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        first_unit;
    logic        final_unit;
    logic        empty_string;

    modport source (output valid, code_unit, first_unit, final_unit, empty_string,
                    input ready);
    modport sink (input valid, code_unit, first_unit, final_unit, empty_string,
                  output ready);
endinterface

interface jse_char_if;
    logic        valid;
    logic        ready;
    logic [15:0] out_char;
    logic        run_end;

    modport source (output valid, out_char, run_end, input ready);
    modport sink (input valid, out_char, run_end, output ready);
endinterface

interface jse_cfg_if;
    logic valid;
    logic ready;
    logic relaxed_escaping;

    modport source (output valid, relaxed_escaping, input ready);
    modport sink (input valid, relaxed_escaping, output ready);
endinterface

// ----- rtl/jse_front.sv -----
// ----------------------------------------------------------------------------
// JSON string escaper front end
// Accepts code units, holds the escaping mode and classifies each request.
// ----------------------------------------------------------------------------
module jse_front
    import jse_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    jse_unit_if.sink  unit_ch,
    jse_cfg_if.sink   cfg_ch,
    input  logic      full,
    output logic      push,
    output jse_desc_t push_data
);

    logic        relaxed_reg;
    logic [15:0] c;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            relaxed_reg <= 1'b0;
        end
        else if (cfg_ch.valid)
        begin
            relaxed_reg <= cfg_ch.relaxed_escaping;
        end
    end

    assign unit_ch.ready = !full;
    assign push          = unit_ch.valid && !full;
    assign c             = unit_ch.code_unit;

    always_comb
    begin
        push_data.first = unit_ch.first_unit;
        push_data.last  = unit_ch.final_unit;
        push_data.ch    = c;
        push_data.kind  = KIND_RAW;
        priority if (unit_ch.empty_string)
        begin
            push_data.kind  = KIND_EMPTY;
            push_data.first = 1'b1;
            push_data.last  = 1'b1;
        end
        else if (c == CH_QUOTE || c == CH_BSLASH)
        begin
            push_data.kind = KIND_PAIR;
        end
        else if (c == CH_LF)
        begin
            push_data.kind = KIND_PAIR;
            push_data.ch   = CH_LOW_N;
        end
        else if (c == CH_CR)
        begin
            push_data.kind = KIND_PAIR;
            push_data.ch   = CH_LOW_R;
        end
        else if (c == CH_NUL)
        begin
            push_data.kind = KIND_UESC;
        end
        else if (relaxed_reg && (c < CH_SPACE || c == CH_SLASH))
        begin
            push_data.kind = KIND_RAW;
        end
        else if (c == CH_SLASH)
        begin
            push_data.kind = KIND_PAIR;
        end
        else if (c == CH_BS)
        begin
            push_data.kind = KIND_PAIR;
            push_data.ch   = CH_LOW_B;
        end
        else if (c == CH_FF)
        begin
            push_data.kind = KIND_PAIR;
            push_data.ch   = CH_LOW_F;
        end
        else if (c == CH_TAB)
        begin
            push_data.kind = KIND_PAIR;
            push_data.ch   = CH_LOW_T;
        end
        else if (c < CH_SPACE)
        begin
            push_data.kind = KIND_UESC;
        end
        else
        begin
            push_data.kind = KIND_RAW;
        end
    end

endmodule

// ----- rtl/jse_fifo.sv -----
// ----------------------------------------------------------------------------
// JSON string escaper request queue
// Short queue of classified requests between the front and back ends.
// ----------------------------------------------------------------------------
module jse_fifo
    import jse_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  jse_desc_t push_data,
    output logic      full,
    input  logic      pop,
    output jse_desc_t pop_data,
    output logic      empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    jse_desc_t          mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    assign wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/jse_back.sv -----
// ----------------------------------------------------------------------------
// JSON string escaper back end
// Steps through each queued request; one char per cycle unless char_ch stalls.
// ----------------------------------------------------------------------------
module jse_back
    import jse_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  jse_desc_t pop_data,
    input  logic      empty,
    output logic      pop,
    jse_char_if.source char_ch
);

    logic [2:0]  idx_reg;
    logic        out_valid_reg;
    logic [15:0] out_char_reg;
    logic        run_end_reg;

    logic [2:0]  body_len;
    logic [3:0]  total;
    logic [2:0]  last_idx;
    logic [2:0]  j;
    logic        at_last;
    logic        load;
    logic [15:0] chr;
    logic [15:0] body_chr;

    always_comb
    begin
        unique case (pop_data.kind)
            KIND_RAW:   body_len = 3'd1;
            KIND_PAIR:  body_len = 3'd2;
            KIND_UESC:  body_len = 3'd6;
            KIND_EMPTY: body_len = 3'd0;
            default:    body_len = 3'd0;
        endcase
    end

    assign total    = {1'b0, body_len} + 4'(pop_data.first) + 4'(pop_data.last);
    assign last_idx = 3'(total - 4'd1);
    assign at_last  = (idx_reg == last_idx);
    assign j        = idx_reg - 3'(pop_data.first);

    always_comb
    begin
        unique case (pop_data.kind)
            KIND_RAW:   body_chr = pop_data.ch;
            KIND_PAIR:  body_chr = (j == 3'd0) ? CH_BSLASH : pop_data.ch;
            KIND_UESC:
            begin
                unique case (j)
                    3'd0:    body_chr = CH_BSLASH;
                    3'd1:    body_chr = CH_LOW_U;
                    3'd2:    body_chr = CH_ZERO;
                    3'd3:    body_chr = CH_ZERO;
                    3'd4:    body_chr = hex_char(pop_data.ch[7:4]);
                    default: body_chr = hex_char(pop_data.ch[3:0]);
                endcase
            end
            default:    body_chr = CH_QUOTE;
        endcase
    end

    always_comb
    begin
        priority if (pop_data.first && idx_reg == 3'd0)
        begin
            chr = CH_QUOTE;
        end
        else if (j < body_len)
        begin
            chr = body_chr;
        end
        else
        begin
            chr = CH_QUOTE;
        end
    end

    assign load = !out_valid_reg || char_ch.ready;
    assign pop  = load && !empty && at_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 3'd0;
        end
        else if (load)
        begin
            out_valid_reg <= !empty;
            if (!empty)
            begin
                idx_reg <= at_last ? 3'd0 : idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && !empty)
        begin
            out_char_reg <= chr;
            run_end_reg  <= at_last;
        end
    end

    assign char_ch.valid    = out_valid_reg;
    assign char_ch.out_char = out_char_reg;
    assign char_ch.run_end  = run_end_reg;

    a_pop_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> idx_reg == 3'd0)
        else $error("step index not rewound after pop");

    a_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> idx_reg == 3'd0)
        else $error("step index moved with queue empty");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> idx_reg <= last_idx)
        else $error("step index past end of run");

    a_run_end_mark: assert property (@(posedge clk) disable iff (!rst_n)
        (load && !empty) |=> out_valid_reg && (run_end_reg == $past(at_last)))
        else $error("run end mark does not match step");

endmodule

// ----- rtl/json_string_escaper.sv -----
// ----------------------------------------------------------------------------
// JSON string escaper
// Turns a stream of UTF-16 code units into JSON-quoted, escaped text.
// ----------------------------------------------------------------------------
// unit_ch takes one code unit per request with first_unit, final_unit and
// empty_string flags. char_ch returns the escaped text one code unit per
// request; run_end marks the last character caused by an input request.
// cfg_ch writes relaxed_escaping; write it only while the block is idle.
// An input request yields 1 to 8 characters: quotes at the string ends,
// two for a short escape, six for a \u00xx escape.
// The first character of a request passes through the queue and then the
// output register before it is valid.
// While char_ch does not stall, the back end emits one character per cycle,
// so plain units inside a string sustain one request per cycle; an escape
// holds the back end until all its characters are out, while the front end
// keeps taking requests into a FIFO_DEPTH-entry queue.
// When char_ch stalls, the output register holds, the queue fills and
// unit_ch.ready drops once the queue is full.
// Reset empties the queue and clears relaxed_escaping to strict mode.
// ----------------------------------------------------------------------------
module json_string_escaper
    import jse_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    jse_unit_if.sink   unit_ch,
    jse_char_if.source char_ch,
    jse_cfg_if.sink    cfg_ch
);

    logic      push;
    logic      pop;
    logic      full;
    logic      empty;
    jse_desc_t push_data;
    jse_desc_t pop_data;

    jse_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .unit_ch   (unit_ch),
        .cfg_ch    (cfg_ch),
        .full      (full),
        .push      (push),
        .push_data (push_data)
    );

    jse_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    jse_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .pop_data (pop_data),
        .empty    (empty),
        .pop      (pop),
        .char_ch  (char_ch)
    );

endmodule
